// ===== rtl/efsad_pkg.sv =====
// Shared constants, types and functions of the encoder frame sync angle decoder.
package efsad_pkg;

    localparam int FRAME_BYTES = 9;
    localparam int PTR_W       = $clog2(FRAME_BYTES);
    localparam int FRAME_LEN   = 9;
    localparam int CRC_LEN     = 7;
    localparam int OFS_W       = $clog2(FRAME_LEN);

    localparam int ID_W     = 8;
    localparam int COUNT_W  = 18;
    localparam int ANGLE_W  = 19;
    localparam int RAW_W    = 32;
    localparam int ERR_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 19;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [ANGLE_W-1:0] TURN_COUNTS = 19'h40000;

    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_DIR   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ANGLE = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]    device_id;
        logic [COUNT_W-1:0] zero_offset;
        logic               reverse_dir;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic step;
        logic check_lo;
    } crc_ctl_t;

    typedef struct packed {
        logic               frame_found;
        logic [7:0]         function_code;
        logic [7:0]         data_length;
        logic [RAW_W-1:0]   raw_position;
        logic [ANGLE_W-1:0] angle_counts;
        logic [ERR_W-1:0]   error_count;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FRAME_BYTES - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

// ===== rtl/efsad_ring.sv =====
// Circular receive buffer with write pointer, per-entry valid bits and registered read.
module efsad_ring (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_en,
    input  logic [7:0]                 wr_data,
    input  logic [efsad_pkg::PTR_W-1:0] rd_addr,
    output logic [7:0]                 rd_data
);
    import efsad_pkg::*;

    logic [7:0]             mem [FRAME_BYTES];
    logic [FRAME_BYTES-1:0] vld_reg;
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [7:0]             rd_mem_reg;
    logic                   rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
        rd_mem_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_ptr_reg] <= 1'b1;
                wr_ptr_reg          <= ptr_inc(wr_ptr_reg);
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_mem_reg : 8'h00;

endmodule

// ===== rtl/efsad_crc.sv =====
// Shared CRC-16 unit that folds one byte per cycle and checks the received CRC.
module efsad_crc (
    input  logic                aclk,
    input  efsad_pkg::crc_ctl_t ctl,
    input  logic [7:0]          data,
    output logic                match
);
    import efsad_pkg::*;

    logic [15:0] crc_reg;
    logic        lo_ok_reg;

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            crc_reg <= crc_byte(CRC_INIT, data);
        end else if (ctl.step) begin
            crc_reg <= crc_byte(crc_reg, data);
        end
        if (ctl.check_lo) begin
            lo_ok_reg <= (data == crc_reg[7:0]);
        end
    end

    assign match = lo_ok_reg && (data == crc_reg[15:8]);

endmodule

// ===== rtl/efsad_scan.sv =====
// Scan sequencer that walks the ring, checks frames and decodes the angle.
module efsad_scan (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    output logic                        idle,
    input  efsad_pkg::cfg_t             cfg,
    input  logic                        held_load,
    input  logic [efsad_pkg::ANGLE_W-1:0] held_value,
    output logic [efsad_pkg::PTR_W-1:0] rd_addr,
    input  logic [7:0]                  rd_data,
    output logic                        res_valid,
    input  logic                        res_ready,
    output efsad_pkg::result_t          res
);
    import efsad_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_HDR  = 3'd1;
    localparam logic [2:0] ST_BYTE = 3'd2;
    localparam logic [2:0] ST_ANG  = 3'd3;
    localparam logic [2:0] ST_HOLD = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [PTR_W-1:0]   pos_reg, pos_next;
    logic [PTR_W-1:0]   a_reg;
    logic [PTR_W-1:0]   n_reg, n_next;
    logic [OFS_W-1:0]   k_reg, k_next;
    logic [PTR_W-1:0]   scan_start_reg, scan_start_next;
    logic               found_reg, found_next;
    logic [7:0]         fc_reg, fc_next;
    logic [7:0]         dl_reg, dl_next;
    logic [RAW_W-1:0]   raw_reg, raw_next;
    logic [COUNT_W-1:0] t_reg;
    logic [ANGLE_W-1:0] held_reg;
    logic [ERR_W-1:0]   fail_cnt_reg, fail_cnt_next;
    logic               last_pos;
    logic               crc_match;
    crc_ctl_t           crc_ctl;

    efsad_crc u_crc (
        .aclk  (aclk),
        .ctl   (crc_ctl),
        .data  (rd_data),
        .match (crc_match)
    );

    assign last_pos = (n_reg == PTR_W'(FRAME_BYTES - 1));

    always_comb begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        scan_start_next = scan_start_reg;
        found_next      = found_reg;
        fc_next         = fc_reg;
        dl_next         = dl_reg;
        raw_next        = raw_reg;
        fail_cnt_next   = fail_cnt_reg;
        rd_addr         = ptr_inc(a_reg);
        crc_ctl         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                rd_addr = scan_start_reg;
                if (start) begin
                    pos_next   = scan_start_reg;
                    n_next     = '0;
                    found_next = 1'b0;
                    state_next = ST_HDR;
                end
            end
            ST_HDR: begin
                if (rd_data == cfg.device_id) begin
                    crc_ctl.start = 1'b1;
                    k_next        = OFS_W'(1);
                    state_next    = ST_BYTE;
                end else if (last_pos) begin
                    fail_cnt_next = fail_cnt_reg + 1'b1;
                    state_next    = ST_DONE;
                end else begin
                    n_next   = n_reg + 1'b1;
                    pos_next = ptr_inc(pos_reg);
                end
            end
            ST_BYTE: begin
                k_next = k_reg + 1'b1;
                if (k_reg < OFS_W'(CRC_LEN)) begin
                    crc_ctl.step = 1'b1;
                    if (k_reg == OFS_W'(1)) begin
                        fc_next = rd_data;
                    end else if (k_reg == OFS_W'(2)) begin
                        dl_next = rd_data;
                    end else begin
                        raw_next = {raw_reg[RAW_W-9:0], rd_data};
                    end
                end else if (k_reg == OFS_W'(CRC_LEN)) begin
                    crc_ctl.check_lo = 1'b1;
                end else begin
                    if (crc_match) begin
                        found_next      = 1'b1;
                        scan_start_next = pos_reg;
                        state_next      = ST_ANG;
                    end else if (last_pos) begin
                        fail_cnt_next = fail_cnt_reg + 1'b1;
                        state_next    = ST_DONE;
                    end else begin
                        rd_addr    = ptr_inc(pos_reg);
                        n_next     = n_reg + 1'b1;
                        pos_next   = ptr_inc(pos_reg);
                        state_next = ST_HDR;
                    end
                end
            end
            ST_ANG: begin
                state_next = ST_HOLD;
            end
            ST_HOLD: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            scan_start_reg <= '0;
            fail_cnt_reg   <= '0;
            held_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            scan_start_reg <= scan_start_next;
            fail_cnt_reg   <= fail_cnt_next;
            if (held_load) begin
                held_reg <= held_value;
            end else if (state_reg == ST_HOLD) begin
                held_reg <= cfg.reverse_dir ? (TURN_COUNTS - {1'b0, t_reg}) : {1'b0, t_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg   <= pos_next;
        a_reg     <= rd_addr;
        n_reg     <= n_next;
        k_reg     <= k_next;
        found_reg <= found_next;
        fc_reg    <= fc_next;
        dl_reg    <= dl_next;
        raw_reg   <= raw_next;
        if (state_reg == ST_ANG) begin
            t_reg <= raw_reg[COUNT_W-1:0] - cfg.zero_offset;
        end
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb begin
        res.frame_found   = found_reg;
        res.function_code = found_reg ? fc_reg : 8'h00;
        res.data_length   = found_reg ? dl_reg : 8'h00;
        res.raw_position  = found_reg ? raw_reg : '0;
        res.angle_counts  = held_reg;
        res.error_count   = fail_cnt_reg;
    end

    a_start_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_start_reg < PTR_W'(FRAME_BYTES))
        else $error("scan start left the ring");

    a_byte_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BYTE) |-> (k_reg >= OFS_W'(1) && k_reg <= OFS_W'(FRAME_LEN - 1)))
        else $error("frame byte offset out of range");

    a_hdr_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HDR) |-> (a_reg == pos_reg && n_reg < PTR_W'(FRAME_BYTES)))
        else $error("header read does not match scan position");

    a_fail_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(res_valid) && !found_reg |-> fail_cnt_reg == $past(fail_cnt_reg) + 1'b1)
        else $error("failed scan did not advance error count");

endmodule

// ===== rtl/encoder_frame_sync_angle_decoder.sv =====
// Top level of the encoder frame sync angle decoder: ports, configuration and output register.
// A stored byte is written into the ring and yields no result; s_ready stays high.
// A scan command tries the ring positions in turn, comparing each header byte with the device ID;
// on a match the shared CRC unit folds the frame one byte per cycle and checks the received CRC.
// A found frame then passes the angle states; s_ready returns once the result is registered.
// Synchronous active-low reset clears ring, pointers, error count and config, device ID to 1.
module encoder_frame_sync_angle_decoder (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_command,
    input  logic [7:0]                       s_rx_byte,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_frame_found,
    output logic [7:0]                       m_function_code,
    output logic [7:0]                       m_data_length,
    output logic [efsad_pkg::RAW_W-1:0]      m_raw_position,
    output logic [efsad_pkg::ANGLE_W-1:0]    m_angle_counts,
    output logic [efsad_pkg::ERR_W-1:0]      m_error_count,
    input  logic                             cfg_wr_en,
    input  logic [efsad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [efsad_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import efsad_pkg::*;

    cfg_t             cfg_reg;
    logic             held_load;
    logic             scan_idle;
    logic             s_xfer;
    logic [PTR_W-1:0] rd_addr;
    logic [7:0]       rd_data;
    logic             res_valid;
    logic             res_ready;
    result_t          res;
    result_t          out_reg;
    logic             m_valid_reg;

    assign s_ready   = scan_idle;
    assign s_xfer    = s_valid && s_ready;
    assign held_load = cfg_wr_en && (cfg_index == CFG_INITIAL_ANGLE);
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_id   <= ID_W'(1);
            cfg_reg.zero_offset <= '0;
            cfg_reg.reverse_dir <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DEVICE_ID:     cfg_reg.device_id   <= cfg_wr_data[ID_W-1:0];
                CFG_ZERO_OFFSET:   cfg_reg.zero_offset <= cfg_wr_data[COUNT_W-1:0];
                CFG_REVERSE_DIR:   cfg_reg.reverse_dir <= cfg_wr_data[0];
                CFG_INITIAL_ANGLE: ;
                default: ;
            endcase
        end
    end

    efsad_ring u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (s_xfer && !s_command),
        .wr_data (s_rx_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    efsad_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (s_xfer && s_command),
        .idle       (scan_idle),
        .cfg        (cfg_reg),
        .held_load  (held_load),
        .held_value (cfg_wr_data[ANGLE_W-1:0]),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_frame_found   = out_reg.frame_found;
    assign m_function_code = out_reg.function_code;
    assign m_data_length   = out_reg.data_length;
    assign m_raw_position  = out_reg.raw_position;
    assign m_angle_counts  = out_reg.angle_counts;
    assign m_error_count   = out_reg.error_count;

endmodule

// ===== bench/efsad_checker.sv =====
`timescale 1ns / 100ps
// Checker for the frame sync angle decoder: predicts every scan report and compares the outputs.
module efsad_checker #(
    parameter logic CMD_IDLE = 1'b1
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic                             s_command,
    input  logic [7:0]                       s_rx_byte,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic                             m_frame_found,
    input  logic [7:0]                       m_function_code,
    input  logic [7:0]                       m_data_length,
    input  logic [efsad_pkg::RAW_W-1:0]      m_raw_position,
    input  logic [efsad_pkg::ANGLE_W-1:0]    m_angle_counts,
    input  logic [efsad_pkg::ERR_W-1:0]      m_error_count,
    input  logic                             cfg_wr_en,
    input  logic [efsad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [efsad_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output int unsigned                      fail_count,
    output int unsigned                      pending
);
    import efsad_pkg::*;

    logic [7:0]         ring_mem [FRAME_BYTES];
    int                 wr_ptr;
    int                 scan_ptr;
    logic [ERR_W-1:0]   miss_count;
    logic [ANGLE_W-1:0] held_angle;
    logic [ID_W-1:0]    dev_id;
    logic [COUNT_W-1:0] zero_ofs;
    logic               mirror;
    result_t            predicted_reports [$];

    function automatic logic [7:0] ring_at(input int base, input int off);
        return ring_mem[(base + off) % FRAME_BYTES];
    endfunction

    function automatic result_t scan_ring();
        result_t            rep;
        logic [15:0]        crc;
        logic [COUNT_W-1:0] counts;
        logic [ANGLE_W-1:0] turn_pos;
        bit                 hit;
        rep = '0;
        hit = 1'b0;
        for (int n = 0; n < FRAME_BYTES && !hit; n++) begin
            if (ring_mem[scan_ptr] == dev_id) begin
                crc = CRC_INIT;
                for (int i = 0; i < CRC_LEN; i++) begin
                    crc = crc ^ {8'h00, ring_at(scan_ptr, i)};
                    for (int b = 0; b < 8; b++) begin
                        crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
                    end
                end
                if (crc == {ring_at(scan_ptr, 8), ring_at(scan_ptr, 7)}) begin
                    hit = 1'b1;
                    rep.frame_found   = 1'b1;
                    rep.function_code = ring_at(scan_ptr, 1);
                    rep.data_length   = ring_at(scan_ptr, 2);
                    rep.raw_position  = {ring_at(scan_ptr, 3), ring_at(scan_ptr, 4),
                                         ring_at(scan_ptr, 5), ring_at(scan_ptr, 6)};
                    counts = rep.raw_position[COUNT_W-1:0];
                    turn_pos = {1'b0, counts} - {1'b0, zero_ofs};
                    if (counts < zero_ofs) begin
                        turn_pos = turn_pos + TURN_COUNTS;
                    end
                    held_angle = mirror ? (TURN_COUNTS - turn_pos) : turn_pos;
                end
            end
            if (!hit) begin
                scan_ptr = (scan_ptr + 1) % FRAME_BYTES;
            end
        end
        if (!hit) begin
            miss_count = miss_count + 1'b1;
        end
        rep.angle_counts = held_angle;
        rep.error_count  = miss_count;
        return rep;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            foreach (ring_mem[i]) ring_mem[i] = 8'h00;
            wr_ptr     = 0;
            scan_ptr   = 0;
            miss_count = '0;
            held_angle = '0;
            dev_id     = 8'd1;
            zero_ofs   = '0;
            mirror     = 1'b0;
            predicted_reports.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_DEVICE_ID:     dev_id = cfg_wr_data[ID_W-1:0];
                    CFG_ZERO_OFFSET:   zero_ofs = cfg_wr_data[COUNT_W-1:0];
                    CFG_REVERSE_DIR:   mirror = cfg_wr_data[0];
                    CFG_INITIAL_ANGLE: held_angle = cfg_wr_data[ANGLE_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (predicted_reports.size() == 0) begin
                    $error("result transfer with no report expected");
                    fail_count++;
                end else begin
                    want = predicted_reports.pop_front();
                    check_field("frame_found", want.frame_found, m_frame_found);
                    check_field("function_code", want.function_code, m_function_code);
                    check_field("data_length", want.data_length, m_data_length);
                    check_field("raw_position", want.raw_position, m_raw_position);
                    check_field("angle_counts", want.angle_counts, m_angle_counts);
                    check_field("error_count", want.error_count, m_error_count);
                end
            end
            if (s_valid && s_ready) begin
                if (s_command == CMD_IDLE) begin
                    predicted_reports.push_back(scan_ring());
                end else begin
                    ring_mem[wr_ptr] = s_rx_byte;
                    wr_ptr = (wr_ptr + 1) % FRAME_BYTES;
                end
            end
        end
        pending <= predicted_reports.size();
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the frame sync angle decoder: stimulus, register phases and verdict.
module tb_top;
    import efsad_pkg::*;

    localparam logic CMD_STORE   = 1'b0;
    localparam logic CMD_IDLE    = 1'b1;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 240;
    localparam int DRAIN_CYCLES  = 120;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PERIODIC
    } ready_mode_t;

    typedef struct packed {
        logic [ID_W-1:0]    dev_id;
        logic [COUNT_W-1:0] offset;
        logic               mirror;
        logic [ANGLE_W-1:0] start_angle;
    } reg_set_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_command = CMD_STORE;
    logic [7:0]            s_rx_byte = 8'h00;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_frame_found;
    logic [7:0]            m_function_code;
    logic [7:0]            m_data_length;
    logic [RAW_W-1:0]      m_raw_position;
    logic [ANGLE_W-1:0]    m_angle_counts;
    logic [ERR_W-1:0]      m_error_count;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_DEVICE_ID;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    int unsigned           fail_count;
    int unsigned           pending;

    int unsigned           cycle_count = 0;
    int unsigned           ready_tick = 0;
    ready_mode_t           ready_mode = READY_ALWAYS;
    int                    burst_left = 0;
    int                    items_sent = 0;
    reg_set_t              cur;

    encoder_frame_sync_angle_decoder i_dut (.*);

    efsad_checker #(.CMD_IDLE(CMD_IDLE)) i_checker (.*);

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        ready_tick <= ready_tick + 1;
        if (ready_tick % 200 == 0) begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
        end
        case (ready_mode)
            READY_ALWAYS:   m_ready <= 1'b1;
            READY_COIN:     m_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE:   m_ready <= ($urandom_range(0, 3) == 0);
            READY_PERIODIC: m_ready <= ready_tick[2];
            default:        m_ready <= 1'b1;
        endcase
    end

    task automatic send_item(input logic cmd, input logic [7:0] rx);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_rx_byte <= rx;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_frame(input logic [31:0] raw, input logic [7:0] fc,
                              input logic [7:0] dl, input bit corrupt, input int keep);
        logic [8:0][7:0] fb;
        logic [15:0]     crc;
        fb[0] = cur.dev_id;
        fb[1] = fc;
        fb[2] = dl;
        fb[3] = raw[31:24];
        fb[4] = raw[23:16];
        fb[5] = raw[15:8];
        fb[6] = raw[7:0];
        crc = 16'hFFFF;
        for (int i = 0; i < CRC_LEN; i++) begin
            crc = crc ^ {8'h00, fb[i]};
            for (int b = 0; b < 8; b++) begin
                crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
            end
        end
        fb[7] = crc[7:0];
        fb[8] = crc[15:8];
        if (corrupt) begin
            fb[$urandom_range(0, 8)] ^= 8'(1 << $urandom_range(0, 7));
        end
        for (int i = 0; i < keep; i++) begin
            send_item(CMD_STORE, fb[i]);
        end
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [31:0] raw;
        int          pick;
        int          phase_goal;
        cur = '{dev_id: 8'd1, offset: '0, mirror: 1'b0, start_angle: '0};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(CMD_IDLE, 8'h00);
        send_frame(32'hFFFF_FFFF, 8'hFF, 8'h00, 1'b0, 9);
        send_item(CMD_IDLE, 8'hFF);
        send_frame(32'h0000_0000, 8'h00, 8'hFF, 1'b1, 9);
        send_item(CMD_IDLE, 8'h5A);
        send_item(CMD_IDLE, 8'hA5);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                s_valid <= 1'b0;
                wait_drained();
                case (p)
                    1: cur = '{dev_id: 8'd0, offset: '0, mirror: 1'b0, start_angle: '0};
                    2: cur = '{dev_id: 8'd255, offset: 18'h3FFFF, mirror: 1'b1,
                               start_angle: TURN_COUNTS};
                    3: cur = '{dev_id: 8'd1, offset: 18'h20000, mirror: 1'b0,
                               start_angle: TURN_COUNTS};
                    4: cur = '{dev_id: 8'h5A, offset: 18'd1, mirror: 1'b1, start_angle: '0};
                    default: begin
                        cur.dev_id      = 8'($urandom);
                        cur.offset      = 18'($urandom_range(0, 262143));
                        cur.mirror      = 1'($urandom_range(0, 1));
                        cur.start_angle = 19'($urandom_range(0, 262144));
                    end
                endcase
                cfg_wr_en   <= 1'b1;
                cfg_index   <= CFG_DEVICE_ID;
                cfg_wr_data <= CFG_DATA_W'(cur.dev_id);
                @(posedge aclk);
                cfg_index   <= CFG_ZERO_OFFSET;
                cfg_wr_data <= CFG_DATA_W'(cur.offset);
                @(posedge aclk);
                cfg_index   <= CFG_REVERSE_DIR;
                cfg_wr_data <= CFG_DATA_W'(cur.mirror);
                @(posedge aclk);
                cfg_index   <= CFG_INITIAL_ANGLE;
                cfg_wr_data <= CFG_DATA_W'(cur.start_angle);
                @(posedge aclk);
                cfg_wr_en   <= 1'b0;
                send_item(CMD_IDLE, 8'($urandom));
            end
            // A frame sitting exactly on the zero point exercises the full-turn mirror result when reversed.
            send_frame({14'($urandom), cur.offset}, 8'($urandom), 8'($urandom), 1'b0, 9);
            send_item(CMD_IDLE, 8'($urandom));

            phase_goal = items_sent + PHASE_ITEMS;
            while (items_sent < phase_goal) begin
                case ($urandom_range(0, 5))
                    0:       raw = {14'($urandom), cur.offset};
                    1:       raw = '0;
                    2:       raw = '1;
                    default: raw = $urandom;
                endcase
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    repeat ($urandom_range(0, 3)) send_item(CMD_STORE, 8'($urandom));
                    send_frame(raw, 8'($urandom), 8'($urandom),
                               $urandom_range(0, 6) == 0, 9);
                    send_item(CMD_IDLE, 8'($urandom));
                end else if (pick < 72) begin
                    send_item(CMD_IDLE, 8'($urandom));
                end else if (pick < 88) begin
                    repeat ($urandom_range(1, 6)) send_item(CMD_STORE, 8'($urandom));
                end else begin
                    send_frame(raw, 8'($urandom), 8'($urandom), 1'b0,
                               $urandom_range(1, 8));
                    send_item(CMD_IDLE, 8'($urandom));
                end
            end
        end

        s_valid <= 1'b0;
        wait_drained();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
